// File: rtl/pac_pkg.sv
`default_nettype none

package pac_pkg;

    localparam int LEN_W  = 16;
    localparam int TIME_W = 32;
    localparam int RATE_W = 4;
    localparam int FLAG_W = 2;
    localparam int SUM_W  = 17;
    localparam int EXC_W  = 16;
    localparam int VC_W   = 17;
    localparam int NBLK_W = 10;
    localparam int BLKT_W = 25;
    localparam int TAIL_W = 23;
    localparam int MULX_W = 22;

    typedef enum logic [1:0] {
        RSEL_8,
        RSEL_4,
        RSEL_2,
        RSEL_1M
    } t_rsel;

    localparam logic [RATE_W-1:0] RATE_8US = 4'd8;
    localparam logic [RATE_W-1:0] RATE_4US = 4'd4;
    localparam logic [RATE_W-1:0] RATE_2US = 4'd2;

    // Length limits and paddings.
    localparam logic [LEN_W-1:0] LEN_HDR_MAX  = 16'd217;
    localparam logic [LEN_W-1:0] CAP1_LIMIT   = 16'd206;
    localparam logic [7:0]       CAP1_SAT     = 8'd255;
    localparam logic [7:0]       CAP1_OFFS    = 8'd48;
    localparam logic [8:0]       CAP1_PAD     = 9'd5;
    localparam logic [LEN_W-1:0] CAP2_LIMIT   = 16'd240;
    localparam logic [7:0]       CAP2_SAT     = 8'd241;
    localparam logic [8:0]       CAP2_PAD     = 9'd19;
    localparam logic [EXC_W-1:0] REM_PAD      = 16'd13;
    localparam logic [VC_W-1:0]  CEIL_BIAS    = 17'd29;
    localparam logic [7:0]       BLK_LEN      = 8'd247;

    // Reciprocal constants for the division by the block length.
    localparam logic [31:0] QUOT_MAGIC = 32'h0953f391;
    localparam logic [30:0] CEIL_MAGIC = 31'd2069234231;

    // Fixed time terms, microseconds.
    localparam logic [SUM_W-1:0] ACK_TERM    = 17'h0014a;
    localparam logic [SUM_W-1:0] SHORT_GAP   = 17'h0009c;
    localparam logic [SUM_W-1:0] MID_R2      = 17'h000b4;
    localparam logic [SUM_W-1:0] MID_OTHER   = 17'h00160;
    localparam logic [SUM_W-1:0] END_GAP     = 17'h00098;
    localparam logic [SUM_W-1:0] LONG_A      = 17'h00c14;
    localparam logic [SUM_W-1:0] LONG_R      = 17'h00cac;
    localparam logic [SUM_W-1:0] COD8_FULL   = 17'h043da;
    localparam logic [SUM_W-1:0] COD1M_FULL  = 17'h00992;
    localparam logic [SUM_W-1:0] COD8_MID    = 17'h04328;
    localparam logic [SUM_W-1:0] COD1M_MID   = 17'h008e0;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   base;
        logic [SUM_W-1:0]    ssum;
        logic [EXC_W-1:0]    excess;
        logic [VC_W-1:0]     vc;
        logic [15:0]         q_hi;
        logic [15:0]         c_hi;
        logic                c_nz;
        t_rsel               rsel;
        logic                use_blk;
        logic                use_tail;
    } t_s1;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   hsum;
        logic [NBLK_W-1:0]   nblk;
        logic [EXC_W-1:0]    excess;
        t_rsel               rsel;
        logic                tail_en;
    } t_s2;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   hsum;
        logic [BLKT_W-1:0]   blk;
        logic [TAIL_W-1:0]   tail;
    } t_s3;

    function automatic t_rsel f_rsel(input logic [RATE_W-1:0] rate);
        t_rsel r;
        if (rate == RATE_8US) begin
            r = RSEL_8;
        end else if (rate == RATE_4US) begin
            r = RSEL_4;
        end else if (rate == RATE_2US) begin
            r = RSEL_2;
        end else begin
            r = RSEL_1M;
        end
        return r;
    endfunction

    function automatic logic [8:0] f_uc_over(input t_rsel r);
        logic [8:0] v;
        case (r)
            RSEL_8:  v = 9'h190;
            RSEL_4:  v = 9'h17e;
            RSEL_2:  v = 9'h018;
            default: v = 9'h028;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] f_blk_cost(input t_rsel r);
        logic [14:0] v;
        case (r)
            RSEL_8:  v = 15'h43da;
            RSEL_4:  v = 15'h1308;
            RSEL_2:  v = 15'h0572;
            default: v = 15'h0992;
        endcase
        return v;
    endfunction

    function automatic logic [12:0] f_alt_over(input t_rsel r);
        logic [12:0] v;
        case (r)
            RSEL_8:  v = 13'h12d0;
            RSEL_4:  v = 13'h05ce;
            RSEL_2:  v = 13'h012c;
            default: v = 13'h0250;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] f_cod_over(input t_rsel r);
        logic [14:0] v;
        case (r)
            RSEL_8:  v = 15'h4290;
            RSEL_4:  v = 15'h11be;
            RSEL_2:  v = 15'h0428;
            default: v = 15'h0848;
        endcase
        return v;
    endfunction

    function automatic logic [10:0] f_reply(input t_rsel r);
        logic [10:0] v;
        case (r)
            RSEL_8:  v = 11'h650;
            RSEL_4:  v = 11'h2ae;
            RSEL_2:  v = 11'h064;
            default: v = 11'h0c0;
        endcase
        return v;
    endfunction

    // Per-byte cost: every rate is a power of two, so this is a shift.
    function automatic logic [MULX_W-1:0] f_byte_mul(input logic [15:0] x, input t_rsel r);
        logic [MULX_W-1:0] v;
        case (r)
            RSEL_8:  v = {x, 6'b0};
            RSEL_4:  v = {2'b0, x, 4'b0};
            RSEL_2:  v = {4'b0, x, 2'b0};
            default: v = {3'b0, x, 3'b0};
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pac_ifs.sv
`default_nettype none

interface pac_in_if import pac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  payload_length;
    logic [TIME_W-1:0] start_offset;
    logic [RATE_W-1:0] rate_code;
    logic              coded_mode;
    logic [FLAG_W-1:0] mode_flags;

    modport source (
        output valid, payload_length, start_offset, rate_code, coded_mode, mode_flags,
        input  ready
    );
    modport sink (
        input  valid, payload_length, start_offset, rate_code, coded_mode, mode_flags,
        output ready
    );
endinterface

interface pac_out_if import pac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] airtime;

    modport source (output valid, airtime, input ready);
    modport sink (input valid, airtime, output ready);
endinterface

`default_nettype wire

// File: rtl/pac_stage1.sv
`default_nettype none

module pac_stage1 import pac_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [LEN_W-1:0]  i_payload_length,
    input  wire logic [TIME_W-1:0] i_start_offset,
    input  wire logic [RATE_W-1:0] i_rate_code,
    input  wire logic              i_coded_mode,
    input  wire logic [FLAG_W-1:0] i_mode_flags,
    output t_s1                    o_s1
);

    t_s1              r_s1;
    t_s1              n_s1;
    t_rsel            rsel;
    logic [7:0]       cap1;
    logic [7:0]       cap2;
    logic [SUM_W-1:0] p1;
    logic [SUM_W-1:0] p2;
    logic [SUM_W-1:0] x_term;
    logic [SUM_W-1:0] b1;
    logic [SUM_W-1:0] a_sum;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] ssum;
    logic [EXC_W-1:0] excess;
    logic [VC_W-1:0]  vc;
    logic [47:0]      q_prod;
    logic [47:0]      c_prod;

    assign rsel = f_rsel(i_rate_code);

    // Header length terms for the two capped lengths.
    always_comb begin
        cap1 = (i_payload_length > CAP1_LIMIT) ? CAP1_SAT
                                               : i_payload_length[7:0] + CAP1_OFFS;
        cap2 = (i_payload_length > CAP2_LIMIT) ? CAP2_SAT : i_payload_length[7:0];
        p1 = SUM_W'(f_byte_mul({7'b0, 9'(cap1) + CAP1_PAD}, rsel))
             + SUM_W'(f_uc_over(rsel));
        p2 = SUM_W'(f_byte_mul({7'b0, 9'(cap2) + CAP2_PAD}, rsel))
             + SUM_W'(f_uc_over(rsel));
    end

    // Everything except the start offset and the block terms.
    always_comb begin
        if (i_mode_flags[1]) begin
            x_term = SUM_W'(f_alt_over(rsel));
        end else if (i_coded_mode) begin
            x_term = SUM_W'(f_cod_over(rsel));
        end else begin
            x_term = p1;
        end
        b1 = ACK_TERM + x_term;
        if (i_rate_code[3:2] == 2'b00) begin
            a_sum = b1 + SHORT_GAP + ((rsel == RSEL_2) ? MID_R2 : MID_OTHER);
            r_sum = a_sum + END_GAP;
        end else begin
            a_sum = b1 + LONG_A;
            r_sum = b1 + LONG_R;
        end

        if (i_mode_flags == 2'b00) begin
            if (!i_coded_mode) begin
                ssum = ACK_TERM + p1;
            end else if (rsel == RSEL_8) begin
                ssum = COD8_FULL;
            end else if (rsel == RSEL_1M) begin
                ssum = COD1M_FULL;
            end else begin
                ssum = ACK_TERM + SUM_W'(f_cod_over(rsel));
            end
        end else if (i_mode_flags[0]) begin
            ssum = r_sum + SUM_W'(f_reply(rsel));
        end else if (i_coded_mode) begin
            if (rsel == RSEL_8) begin
                ssum = a_sum + COD8_MID;
            end else if (rsel == RSEL_1M) begin
                ssum = a_sum + COD1M_MID;
            end else begin
                ssum = r_sum + SUM_W'(f_cod_over(rsel));
            end
        end else begin
            ssum = r_sum + p2;
        end
    end

    // Reciprocal products for the floor and ceiling block counts.
    always_comb begin
        excess = i_payload_length - LEN_HDR_MAX;
        vc     = {1'b0, i_payload_length} + CEIL_BIAS;
        q_prod = QUOT_MAGIC * {16'b0, excess};
        c_prod = {17'b0, CEIL_MAGIC} * {31'b0, vc};
    end

    always_comb begin
        n_s1.valid    = i_valid;
        n_s1.base     = i_start_offset;
        n_s1.ssum     = ssum;
        n_s1.excess   = excess;
        n_s1.vc       = vc;
        n_s1.q_hi     = q_prod[47:32];
        n_s1.c_hi     = c_prod[47:32];
        n_s1.c_nz     = |c_prod[31:0];
        n_s1.rsel     = rsel;
        n_s1.use_blk  = !i_mode_flags[0] && (i_payload_length > LEN_HDR_MAX);
        n_s1.use_tail = !i_coded_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// File: rtl/pac_stage2.sv
`default_nettype none

module pac_stage2 import pac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_s1  i_s1,
    output t_s2       o_s2
);

    t_s2              r_s2;
    t_s2              n_s2;
    logic [EXC_W-1:0] diff;
    logic [16:0]      q_sum;
    logic [7:0]       q_floor;
    logic [VC_W-1:0]  mag;
    logic [VC_W-1:0]  vc_left;

    always_comb begin
        // Floor quotient keeps only eight bits, so very long payloads wrap it.
        diff    = i_s1.excess - i_s1.q_hi;
        q_sum   = {1'b0, i_s1.q_hi} + {2'b0, diff[15:1]};
        q_floor = q_sum[14:7];
        mag     = {1'b0, i_s1.c_hi} + {16'b0, i_s1.c_nz};
        vc_left = i_s1.vc - mag;

        n_s2.valid   = i_s1.valid;
        n_s2.hsum    = i_s1.base + {15'b0, i_s1.ssum};
        n_s2.excess  = i_s1.excess;
        n_s2.rsel    = i_s1.rsel;
        n_s2.tail_en = i_s1.use_blk && i_s1.use_tail;
        if (!i_s1.use_blk) begin
            n_s2.nblk = '0;
        end else if (i_s1.use_tail) begin
            n_s2.nblk = {2'b0, q_floor};
        end else begin
            n_s2.nblk = vc_left[16:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// File: rtl/pac_stage3.sv
`default_nettype none

module pac_stage3 import pac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_s2  i_s2,
    output t_s3       o_s3
);

    t_s3               r_s3;
    t_s3               n_s3;
    logic [EXC_W-1:0]  used;
    logic [EXC_W-1:0]  rem;
    logic [MULX_W-1:0] rem_cost;

    always_comb begin
        // On the tail path the block count is the wrapped floor quotient.
        used     = {8'b0, i_s2.nblk[7:0]} * {8'b0, BLK_LEN};
        rem      = i_s2.excess - used;
        rem_cost = f_byte_mul(rem + REM_PAD, i_s2.rsel);

        n_s3.valid = i_s2.valid;
        n_s3.hsum  = i_s2.hsum;
        n_s3.blk   = {5'b0, i_s2.nblk} * {10'b0, f_blk_cost(i_s2.rsel)};
        if (i_s2.tail_en && (rem != '0)) begin
            n_s3.tail = TAIL_W'(rem_cost) + TAIL_W'(f_uc_over(i_s2.rsel))
                        + TAIL_W'(ACK_TERM);
        end else begin
            n_s3.tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

// File: rtl/packet_airtime_calculator.sv
// Requests pass through four register stages, one request per cycle while the
// output register is free; the reciprocal products sit in the first stage and
// the block products in the third.
// Backpressure on the result channel holds every stage in place.
// Reset (synchronous, active low) clears only the stage valid bits.
`default_nettype none

module packet_airtime_calculator import pac_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pac_in_if.sink     i_req,
    pac_out_if.source  o_rsp
);

    t_s1               s1;
    t_s2               s2;
    t_s3               s3;
    logic              adv;
    logic              r_valid;
    logic [TIME_W-1:0] r_airtime;

    // The whole pipeline moves whenever the output register is free.
    assign adv         = !r_valid || o_rsp.ready;
    assign i_req.ready = adv;

    pac_stage1 u_stage1 (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_valid          (i_req.valid),
        .i_payload_length (i_req.payload_length),
        .i_start_offset   (i_req.start_offset),
        .i_rate_code      (i_req.rate_code),
        .i_coded_mode     (i_req.coded_mode),
        .i_mode_flags     (i_req.mode_flags),
        .o_s1             (s1)
    );

    pac_stage2 u_stage2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    pac_stage3 u_stage3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_s2    (s2),
        .o_s3    (s3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_airtime <= s3.hsum + {7'b0, s3.blk} + {9'b0, s3.tail};
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.airtime = r_airtime;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    import pac_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    // Bit positions inside mode_flags.
    localparam int FLAG_REPLY = 0;
    localparam int FLAG_ALT   = 1;

    localparam logic [RATE_W-1:0] RATE_MAX_CODE = 4'hf;

    localparam bit [31:0] HDR_LEN     = 32'd217;
    localparam bit [31:0] HDR_CLAMP   = 32'd216;
    localparam bit [31:0] BLOCK_BYTES = 32'd247;
    localparam bit [31:0] RECIP_FLOOR = 32'h0953f391;
    localparam bit [31:0] RECIP_CEIL  = 32'd2069234231;
    localparam bit [31:0] ACK_US      = 32'h14a;

    localparam bit [31:0] UC_OVER_US  [4] = '{32'h190, 32'h17e, 32'h18, 32'h28};
    localparam bit [31:0] BYTE_US     [4] = '{32'h40, 32'h10, 32'h4, 32'h8};
    localparam bit [31:0] BLOCK_US    [4] = '{32'h43da, 32'h1308, 32'h572, 32'h992};
    localparam bit [31:0] ALT_OVER_US [4] = '{32'h12d0, 32'h5ce, 32'h12c, 32'h250};
    localparam bit [31:0] COD_OVER_US [4] = '{32'h4290, 32'h11be, 32'h428, 32'h848};
    localparam bit [31:0] REPLY_US    [4] = '{32'h650, 32'h2ae, 32'h64, 32'hc0};

    typedef struct {
        bit [LEN_W-1:0]  len;
        bit [TIME_W-1:0] offset;
        bit [RATE_W-1:0] rate;
        bit              coded;
        bit [FLAG_W-1:0] flags;
    } t_airtime_req;

    typedef struct {
        t_airtime_req    req;
        bit [TIME_W-1:0] airtime;
    } t_airtime_expect;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pac_in_if  req_if ();
    pac_out_if rsp_if ();

    packet_airtime_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_airtime_expect pending_airtimes[$];
    int mismatches  = 0;
    int n_sent      = 0;
    int n_coded     = 0;
    int n_blocked   = 0;
    int n_checked   = 0;
    int cycle_count = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int long_hold     = 0;

    // ------------------------------------------------------------------
    // Airtime predictor
    // ------------------------------------------------------------------
    function automatic t_rsel rate_class(bit [RATE_W-1:0] rate);
        if (rate == RATE_8US) return RSEL_8;
        if (rate == RATE_4US) return RSEL_4;
        if (rate == RATE_2US) return RSEL_2;
        return RSEL_1M;
    endfunction

    // Floor of v/247 by reciprocal multiply; the quotient is kept to 8 bits.
    function automatic bit [31:0] floor_blocks(bit [31:0] v);
        bit [63:0] prod;
        bit [31:0] hi;
        prod = {32'd0, RECIP_FLOOR} * {32'd0, v};
        hi = prod[63:32];
        return ((hi + ((v - hi) >> 1)) >> 7) & 32'hff;
    endfunction

    function automatic bit [31:0] coded_block_count(bit [31:0] len);
        bit [31:0] v;
        bit [63:0] mag;
        v = ((len - HDR_LEN) & 32'hffff) + 32'hf6;
        mag = ({32'd0, RECIP_CEIL} * {32'd0, v} + 64'hffff_ffff) >> 32;
        return (v - mag[31:0]) >> 7;
    endfunction

    function automatic bit [31:0] block_tail(bit [31:0] acc, bit [31:0] len, int ri);
        bit [31:0] excess;
        bit [31:0] q;
        bit [31:0] rem;
        bit [31:0] c;
        if (len <= HDR_LEN) return acc;
        excess = (len - HDR_LEN) & 32'hffff;
        q = floor_blocks(excess);
        acc += q * BLOCK_US[ri];
        rem = (excess - q * BLOCK_BYTES) & 32'hffff;
        if (rem != 0) begin
            c = ((rem + 32'd8) & 32'hffff) + 32'd5;
            acc += c * BYTE_US[ri] + UC_OVER_US[ri] + ACK_US;
        end
        return acc;
    endfunction

    function automatic bit [31:0] predict_airtime(t_airtime_req rq);
        t_rsel     rs;
        int        ri;
        bit [31:0] len;
        bit [31:0] base;
        bit [31:0] capped;
        bit [31:0] res;
        bit [31:0] mid;
        len  = rq.len;
        base = rq.offset;
        rs   = rate_class(rq.rate);
        ri   = int'(rs);
        capped = ((len > HDR_CLAMP) ? HDR_LEN : len) + 32'h30;
        if (capped > 32'hfe) capped = 32'hff;

        if (rq.flags == '0) begin
            if (!rq.coded) begin
                res = base + ACK_US + (capped + 32'd5) * BYTE_US[ri] + UC_OVER_US[ri];
                return block_tail(res, len, ri);
            end
            // The 8 us and 1M coded paths add the acknowledge and coded overhead terms as one constant.
            case (rs)
                RSEL_8:  res = base + 32'h43da;
                RSEL_1M: res = base + 32'h992;
                default: res = base + ACK_US + COD_OVER_US[ri];
            endcase
            if (len > HDR_LEN) res += coded_block_count(len) * BLOCK_US[ri];
            return res;
        end

        if (rq.flags[FLAG_ALT]) begin
            base += ACK_US + ALT_OVER_US[ri];
        end else if (rq.coded) begin
            base += ACK_US + COD_OVER_US[ri];
        end else begin
            base += ACK_US + (capped + 32'd5) * BYTE_US[ri] + UC_OVER_US[ri];
        end

        // Any rate code with either of bits 3:2 set takes the long gap.
        if (rq.rate[3:2] == 2'b00) begin
            base += 32'h9c;
            mid = base + ((rs == RSEL_2) ? 32'hb4 : 32'h160);
            res = mid + 32'h98;
        end else begin
            mid = base + 32'hc14;
            res = base + 32'hcac;
        end

        if (rq.flags[FLAG_REPLY]) return res + REPLY_US[ri];

        if (rq.coded) begin
            case (rs)
                RSEL_8:  res = mid + 32'h4328;
                RSEL_1M: res = mid + 32'h8e0;
                default: res += COD_OVER_US[ri];
            endcase
            if (len > HDR_LEN) res += coded_block_count(len) * BLOCK_US[ri];
            return res;
        end

        capped = (len > 32'd240) ? 32'd241 : len;
        res += (capped + 32'd19) * BYTE_US[ri] + UC_OVER_US[ri];
        return block_tail(res, len, ri);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_airtime_req random_request();
        t_airtime_req rq;
        int           sel;
        int           k;
        sel = $urandom_range(99);
        if (sel < 30) begin
            rq.len = LEN_W'($urandom_range(0, 255));
        end else if (sel < 55) begin
            rq.len = LEN_W'($urandom_range(200, 480));
        end else if (sel < 70) begin
            // Close to a block boundary.
            k = $urandom_range(0, 264);
            rq.len = LEN_W'(217 + 247 * k + $urandom_range(0, 4) - 2);
        end else if (sel < 80) begin
            rq.len = LEN_W'($urandom_range(63000, 65535));
        end else begin
            rq.len = LEN_W'($urandom);
        end
        rq.offset = $urandom;
        if ($urandom_range(99) < 20) rq.offset = 32'hffff_ffff - $urandom_range(0, 40000);
        case ($urandom_range(4))
            0:       rq.rate = RATE_8US;
            1:       rq.rate = RATE_4US;
            2:       rq.rate = RATE_2US;
            default: rq.rate = RATE_W'($urandom);
        endcase
        rq.coded = 1'($urandom);
        rq.flags = FLAG_W'($urandom);
        return rq;
    endfunction

    task automatic send_request(input t_airtime_req rq);
        int gap;
        req_if.valid          <= 1'b1;
        req_if.payload_length <= rq.len;
        req_if.start_offset   <= rq.offset;
        req_if.rate_code      <= rq.rate;
        req_if.coded_mode     <= rq.coded;
        req_if.mode_flags     <= rq.flags;
        do @(posedge i_clk); while (!req_if.ready);
        pending_airtimes.push_back('{req: rq, airtime: predict_airtime(rq)});
        n_sent++;
        if (rq.coded) n_coded++;
        if (rq.len > HDR_LEN) n_blocked++;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            gap = pick_gap();
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_airtimes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_length_edges();
        bit [LEN_W-1:0]  lens [11] = '{16'd0, 16'd206, 16'd207, 16'd217, 16'd218, 16'd240,
                                       16'd241, 16'd464, 16'd465, 16'd63449, 16'hffff};
        bit [RATE_W-1:0] rates [4] = '{RATE_8US, RATE_4US, RATE_2US, RATE_MAX_CODE};
        t_airtime_req    rq;
        for (int i = 0; i < 11; i++) begin
            rq.len    = lens[i];
            rq.offset = i[0] ? 32'hffff_ffff : 32'h0;
            rq.rate   = rates[i % 4];
            rq.coded  = i[1];
            rq.flags  = FLAG_W'(i[3:2]);
            send_request(rq);
        end
    endtask

    task automatic test_rate_sweep();
        t_airtime_req rq;
        for (int r = 0; r < 16; r++) begin
            rq.len    = LEN_W'(200 + 37 * r);
            rq.offset = $urandom;
            rq.rate   = RATE_W'(r);
            rq.coded  = r[0];
            rq.flags  = FLAG_W'(r[2:1] ^ {r[3], r[3]});
            send_request(rq);
        end
    endtask

    task automatic test_random_mix(input int count);
        int pcts [3] = '{0, 10, 40};
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                src_idle_pct  = pcts[$urandom_range(2)];
                sink_idle_pct = pcts[$urandom_range(2)];
            end
            send_request(random_request());
        end
    endtask

    task automatic test_back_to_back(input int count);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    // The result side holds off while requests keep coming, so the
    // pipeline fills and must stall its input.
    task automatic test_output_backpressure(input int count);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        long_hold     = 120;
        for (int i = 0; i < count; i++) send_request(random_request());
        req_if.valid <= 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (long_hold > 0) begin
                stall_left = long_hold - 1;
                long_hold  = 0;
                rsp_if.ready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
                stall_left = pick_gap() - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : airtime_check
        t_airtime_expect exp_item;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_airtimes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected airtime transfer: %h", rsp_if.airtime);
            end else begin
                exp_item = pending_airtimes.pop_front();
                n_checked++;
                if (rsp_if.airtime !== exp_item.airtime) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"Airtime mismatch: len=%0d offset=%h rate=%0d",
                                  " coded=%0d flags=%0d expected %h got %h"},
                                 exp_item.req.len, exp_item.req.offset, exp_item.req.rate,
                                 exp_item.req.coded, exp_item.req.flags,
                                 exp_item.airtime, rsp_if.airtime);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.payload_length <= '0;
        req_if.start_offset   <= '0;
        req_if.rate_code      <= '0;
        req_if.coded_mode     <= 1'b0;
        req_if.mode_flags     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_edges();
        test_rate_sweep();
        test_random_mix(450);
        test_back_to_back(150);
        test_output_backpressure(50);

        req_if.valid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (pending_airtimes.size() != 0) mismatches++;

        $display("Sent %0d airtime requests (%0d coded, %0d longer than one header block),",
                 n_sent, n_coded, n_blocked);
        $display("checked %0d results with random stalls on both sides; %0d mismatches.",
                 n_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/pac_pkg.sv
rtl/pac_ifs.sv
rtl/pac_stage1.sv
rtl/pac_stage2.sv
rtl/pac_stage3.sv
rtl/packet_airtime_calculator.sv
tb/testbench.sv
